// File: src/sibling_maternal_dosage_unit_macros.svh
// ---------------------------------------------------------------------------
// Sibling maternal dosage unit: assertion macros
// Shared concurrent assertion forms; clock clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef SIBLING_MATERNAL_DOSAGE_UNIT_MACROS_SVH
`define SIBLING_MATERNAL_DOSAGE_UNIT_MACROS_SVH

// same-cycle implication
`define SMDOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMDOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/smdos_pkg.sv
// ---------------------------------------------------------------------------
// smdos_pkg
// Types and constants shared by the sibling maternal dosage unit.
// ---------------------------------------------------------------------------
package smdos_pkg;

  localparam int WORK_MAX_BITS = 30;  // widest frequency kept for arithmetic
  localparam int FRAC_BITS     = 16;  // dosage fraction bits
  localparam int QUOT_BITS     = FRAC_BITS + 1;  // one integer bit, ratio < 2
  localparam int DOSAGE_BITS   = 18;

  // genotype code {!bit_b, !bit_a}
  typedef enum logic [1:0] {
    GT_HOM_ALT = 2'b00,
    GT_HET     = 2'b01,
    GT_BAD     = 2'b10,
    GT_AA      = 2'b11
  } geno_t;

  // unordered genotype pair
  typedef enum logic [2:0] {
    PAIR_AA_AA   = 3'd0,
    PAIR_AA_HET  = 3'd1,
    PAIR_AA_ALT  = 3'd2,
    PAIR_HET_HET = 3'd3,
    PAIR_HET_ALT = 3'd4,
    PAIR_ALT_ALT = 3'd5,
    PAIR_BAD     = 3'd6
  } pair_t;

  // per-stage control travelling with each item
  typedef struct packed {
    logic valid;
    logic invalid;
    logic last;
  } ctl_t;

  function automatic pair_t pair_class(geno_t g1, geno_t g2);
    geno_t lo;
    geno_t hi;
    pair_t pc;
    lo = (g1 < g2) ? g1 : g2;
    hi = (g1 < g2) ? g2 : g1;
    priority if (g1 == GT_BAD || g2 == GT_BAD) begin
      pc = PAIR_BAD;
    end else if (lo == GT_AA) begin
      pc = PAIR_AA_AA;
    end else if (lo == GT_HET && hi == GT_AA) begin
      pc = PAIR_AA_HET;
    end else if (lo == GT_HOM_ALT && hi == GT_AA) begin
      pc = PAIR_AA_ALT;
    end else if (lo == GT_HET && hi == GT_HET) begin
      pc = PAIR_HET_HET;
    end else if (lo == GT_HOM_ALT && hi == GT_HET) begin
      pc = PAIR_HET_ALT;
    end else begin
      pc = PAIR_ALT_ALT;
    end
    return pc;
  endfunction

endpackage

// File: src/smdos_prep.sv
// ---------------------------------------------------------------------------
// smdos_prep
// Two-stage operand build: p = 1 - freq and p*p, then numerator and
// denominator of the dosage ratio for the genotype pair.
// ---------------------------------------------------------------------------
module smdos_prep import smdos_pkg::*; #(
  parameter int FREQ_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctl_t                 ctl_in,
  input  geno_t                code1,
  input  geno_t                code2,
  input  logic [FREQ_BITS-1:0] allele_freq,
  output ctl_t                 ctl_out,
  output logic [2*((FREQ_BITS > WORK_MAX_BITS) ? WORK_MAX_BITS : FREQ_BITS)+1:0] num,
  output logic [2*((FREQ_BITS > WORK_MAX_BITS) ? WORK_MAX_BITS : FREQ_BITS)+1:0] den
);

  localparam int W  = (FREQ_BITS > WORK_MAX_BITS) ? WORK_MAX_BITS : FREQ_BITS;
  localparam int DW = 2 * W + 2;
  localparam logic [DW-1:0] S_X  = DW'(1) << W;
  localparam logic [DW-1:0] S2_X = DW'(1) << (2 * W);

  // stage A: frequency, p, p squared
  logic [W-1:0]  f_in;
  logic [W:0]    p_in;
  logic [DW-1:0] p2_in;

  logic [W-1:0]  a_f;
  logic [W:0]    a_p;
  logic [DW-1:0] a_p2;
  pair_t         a_pair;
  ctl_t          a_ctl;

  assign f_in  = allele_freq[FREQ_BITS-1 -: W];  // low bits dropped when wide
  assign p_in  = {1'b1, W'(0)} - {1'b0, f_in};
  assign p2_in = p_in * p_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (en) begin
      a_ctl.valid   <= ctl_in.valid;
      a_ctl.last    <= ctl_in.last;
      a_ctl.invalid <= (pair_class(code1, code2) == PAIR_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_f    <= f_in;
      a_p    <= p_in;
      a_p2   <= p2_in;
      a_pair <= pair_class(code1, code2);
    end
  end

  // stage B: ratio operands
  logic [DW-1:0] f_x;
  logic [DW-1:0] ps_x;
  logic [DW-1:0] num_next;
  logic [DW-1:0] den_next;

  assign f_x  = DW'(a_f);
  assign ps_x = DW'(a_p) << W;

  always_comb begin
    unique case (a_pair)
      PAIR_AA_AA: begin
        num_next = f_x;
        den_next = (S_X << 1) - f_x;
      end
      PAIR_AA_HET: begin
        num_next = S_X;
        den_next = (S_X << 1) - f_x;
      end
      PAIR_AA_ALT: begin
        num_next = S_X;
        den_next = S_X;
      end
      PAIR_HET_HET: begin
        // 3S^2 - 2P^2 over 2S^2 + 2PS - 2P^2 (mod 2^DW, result fits)
        num_next = S2_X + (S2_X << 1) - (a_p2 << 1);
        den_next = (S2_X << 1) + (ps_x << 1) - (a_p2 << 1);
      end
      PAIR_HET_ALT: begin
        num_next = S_X + (f_x << 1);
        den_next = S_X + f_x;
      end
      PAIR_ALT_ALT: begin
        num_next = S_X + f_x + (f_x << 1);
        den_next = S_X + f_x;
      end
      default: begin
        // invalid pair: zero quotient
        num_next = '0;
        den_next = S_X;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= num_next;
      den <= den_next;
    end
  end

endmodule

// File: src/smdos_cell.sv
// ---------------------------------------------------------------------------
// smdos_cell
// One restoring-division cell: compare, conditional subtract, one quotient
// bit; hands remainder, divisor and quotient to the next cell.
// ---------------------------------------------------------------------------
module smdos_cell import smdos_pkg::*; #(
  parameter int DW = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctl_t                 ctl_in,
  input  logic [DW:0]          r_in,
  input  logic [DW-1:0]        d_in,
  input  logic [QUOT_BITS-1:0] q_in,
  output ctl_t                 ctl_out,
  output logic [DW:0]          r_out,
  output logic [DW-1:0]        d_out,
  output logic [QUOT_BITS-1:0] q_out
);

  logic        ge;
  logic [DW:0] diff;
  logic [DW:0] rem;

  assign ge   = (r_in >= {1'b0, d_in});
  assign diff = r_in - {1'b0, d_in};
  assign rem  = ge ? diff : r_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= {rem[DW-1:0], 1'b0};  // rem < d, so the shift cannot overflow
      d_out <= d_in;
      q_out <= {q_in[QUOT_BITS-2:0], ge};
    end
  end

endmodule

// File: src/sibling_maternal_dosage_unit.sv
// ---------------------------------------------------------------------------
// sibling_maternal_dosage_unit
// Pipeline: input transfer to result valid through 2 operand stages, then
//   17 division cells.
// Throughput: one marker per cycle while the output is not stalled; set by
//   the cell chain, one quotient bit per cell, every stage registered.
// Reset: rst clears every stage valid bit; no result pending afterwards.
// ---------------------------------------------------------------------------
module sibling_maternal_dosage_unit import smdos_pkg::*; #(
  parameter int FREQ_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // marker input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   sib1_bit_a,
  input  logic                   sib1_bit_b,
  input  logic                   sib2_bit_a,
  input  logic                   sib2_bit_b,
  input  logic [FREQ_BITS-1:0]   allele_freq,
  input  logic                   last_marker,
  // dosage result
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DOSAGE_BITS-1:0] dosage,
  output logic                   invalid_pair,
  output logic                   last_result
);

  // Working frequency width and ratio operand widths.
  localparam int W  = (FREQ_BITS > WORK_MAX_BITS) ? WORK_MAX_BITS : FREQ_BITS;
  localparam int DW = 2 * W + 2;

  // Whole pipe advances together; it freezes only while a result sits at
  // the output and the sink does not take it. Empty stages are not closed up
  // during a stall; a new transfer is taken whenever the output is not blocked.
  logic en;
  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;

  // Genotype codes come from the inverted stored bits.
  geno_t code1;
  geno_t code2;
  ctl_t  in_ctl;

  assign code1  = geno_t'({~sib1_bit_b, ~sib1_bit_a});
  assign code2  = geno_t'({~sib2_bit_b, ~sib2_bit_a});
  assign in_ctl = '{valid: in_valid, invalid: 1'b0, last: last_marker};

  // Operand build: numerator and denominator of the pair's ratio.
  ctl_t          prep_ctl;
  logic [DW-1:0] num;
  logic [DW-1:0] den;

  smdos_prep #(
    .FREQ_BITS (FREQ_BITS)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .ctl_in      (in_ctl),
    .code1       (code1),
    .code2       (code2),
    .allele_freq (allele_freq),
    .ctl_out     (prep_ctl),
    .num         (num),
    .den         (den)
  );

  // Division chain. Every ratio is below 2, so the first cell yields the
  // integer bit and the next 16 the fraction (rounded toward zero). A fixed
  // pair (aa with AA) and the invalid case enter as plain 1/1 and 0/S.
  ctl_t                 ctl_c [0:QUOT_BITS];
  logic [DW:0]          r_c   [0:QUOT_BITS];
  logic [DW-1:0]        d_c   [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] q_c   [0:QUOT_BITS];

  assign ctl_c[0] = prep_ctl;
  assign r_c[0]   = {1'b0, num};
  assign d_c[0]   = den;
  assign q_c[0]   = '0;

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
    smdos_cell #(
      .DW (DW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_c[i]),
      .r_in    (r_c[i]),
      .d_in    (d_c[i]),
      .q_in    (q_c[i]),
      .ctl_out (ctl_c[i+1]),
      .r_out   (r_c[i+1]),
      .d_out   (d_c[i+1]),
      .q_out   (q_c[i+1])
    );
  end

  // Last cell's registers are the output register.
  assign out_valid    = ctl_c[QUOT_BITS].valid;
  assign dosage       = DOSAGE_BITS'(q_c[QUOT_BITS]);
  assign invalid_pair = ctl_c[QUOT_BITS].invalid;
  assign last_result  = ctl_c[QUOT_BITS].last;

endmodule

// File: src/smdos_checker.sv
// ---------------------------------------------------------------------------
// smdos_checker
// Port-level checks on the sibling maternal dosage unit, bound to the top.
// ---------------------------------------------------------------------------
`include "sibling_maternal_dosage_unit_macros.svh"

module smdos_checker import smdos_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [DOSAGE_BITS-1:0] dosage,
  input logic                   invalid_pair
);

  `SMDOS_ASSERT_IMP(a_invalid_zero, out_valid && invalid_pair, dosage == '0, "invalid pair with nonzero dosage")

  `SMDOS_ASSERT_IMP(a_dosage_below_two, out_valid, dosage[DOSAGE_BITS-1] == 1'b0, "dosage reached 2.0")

  `SMDOS_ASSERT_IMP(a_ready_when_free, !out_valid || out_ready, in_ready, "input stalled with free output")

  `SMDOS_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(dosage), "stalled result changed")

endmodule

bind sibling_maternal_dosage_unit smdos_checker u_smdos_checker (.*);

// File: tb/tb_sibling_maternal_dosage_unit.sv
// ---------------------------------------------------------------------------
// tb_sibling_maternal_dosage_unit
// Self-checking bench for the sibling maternal dosage unit. A scoreboard class
// predicts dosage, invalid flag and last flag for every input transfer and
// compares each output transfer in order. A directed set covers all genotype
// bit patterns and the frequency extremes. Random markers follow in three
// phases with different sender and receiver stall rates.
// ---------------------------------------------------------------------------
module tb_sibling_maternal_dosage_unit import smdos_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FREQ_W = 16;
  localparam logic [DOSAGE_BITS-1:0] DOSAGE_SAT = 18'd131072;  // 2.0
  localparam logic [DOSAGE_BITS-1:0] DOSAGE_ONE = 18'd65536;   // 1.0
  localparam int STALL_LIMIT = 2000;    // cycles with no transfer at all
  localparam int DRAIN_CYCLES = 40;     // about twice the pipeline depth
  localparam int PHASE_ITEMS = 610;

  typedef struct {
    logic [DOSAGE_BITS-1:0] dosage;
    logic                   invalid;
    logic                   is_last;
  } dosage_rec_t;

  // -------------------------------------------------------------------------
  // Scoreboard: predicted results in transfer order
  // -------------------------------------------------------------------------
  class dosage_scoreboard;
    dosage_rec_t expected_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // floor(num * 2^16 / den), clipped at 2.0
    static function logic [DOSAGE_BITS-1:0] q16_quotient(longint unsigned num,
                                                          longint unsigned den);
      longint unsigned res;
      if (num / den >= 2) return DOSAGE_SAT;
      res = (num << FRAC_BITS) / den;
      return (res > DOSAGE_SAT) ? DOSAGE_SAT : res[DOSAGE_BITS-1:0];
    endfunction

    // genotypes must both be valid here
    static function logic [DOSAGE_BITS-1:0] predict_dosage(geno_t g1, geno_t g2,
                                                            logic [FREQ_W-1:0] freq);
      longint unsigned s;
      longint unsigned f;
      longint unsigned p;
      geno_t lo;
      geno_t hi;
      s  = 64'd1 << FREQ_W;
      f  = freq;
      p  = s - f;
      lo = (g1 < g2) ? g1 : g2;
      hi = (g1 < g2) ? g2 : g1;
      if (lo == GT_AA) return q16_quotient(f, 2 * s - f);
      if (hi == GT_AA) begin
        if (lo == GT_HET) return q16_quotient(s, 2 * s - f);
        return DOSAGE_ONE;
      end
      if (lo == GT_HET)
        return q16_quotient(3 * s * s - 2 * p * p, 2 * s * s + 2 * p * s - 2 * p * p);
      if (hi == GT_HET) return q16_quotient(s + 2 * f, s + f);
      return q16_quotient(s + 3 * f, s + f);
    endfunction

    function void note_marker(logic a1, logic b1, logic a2, logic b2,
                              logic [FREQ_W-1:0] freq, logic is_last);
      geno_t g1;
      geno_t g2;
      dosage_rec_t rec;
      g1 = geno_t'({~b1, ~a1});
      g2 = geno_t'({~b2, ~a2});
      rec.invalid = (g1 == GT_BAD) || (g2 == GT_BAD);
      rec.dosage  = rec.invalid ? '0 : predict_dosage(g1, g2, freq);
      rec.is_last = is_last;
      expected_q = {expected_q, rec};
    endfunction

    function void check_dosage(logic [DOSAGE_BITS-1:0] dosage, logic invalid,
                               logic is_last);
      dosage_rec_t rec;
      if (expected_q.size() == 0) begin
        $error("unexpected result: dosage %0d invalid_pair %0b last_result %0b",
               dosage, invalid, is_last);
        mismatches++;
        return;
      end
      rec = expected_q.pop_front();
      if (dosage !== rec.dosage) begin
        $error("dosage: expected %0d, actual %0d", rec.dosage, dosage);
        mismatches++;
      end
      if (invalid !== rec.invalid) begin
        $error("invalid_pair: expected %0b, actual %0b", rec.invalid, invalid);
        mismatches++;
      end
      if (is_last !== rec.is_last) begin
        $error("last_result: expected %0b, actual %0b", rec.is_last, is_last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT and signals
  // -------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   sib1_bit_a;
  logic                   sib1_bit_b;
  logic                   sib2_bit_a;
  logic                   sib2_bit_b;
  logic [FREQ_W-1:0]      allele_freq;
  logic                   last_marker;
  logic                   out_valid;
  logic                   out_ready;
  logic [DOSAGE_BITS-1:0] dosage;
  logic                   invalid_pair;
  logic                   last_result;

  sibling_maternal_dosage_unit #(
    .FREQ_BITS(FREQ_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sib1_bit_a  (sib1_bit_a),
    .sib1_bit_b  (sib1_bit_b),
    .sib2_bit_a  (sib2_bit_a),
    .sib2_bit_b  (sib2_bit_b),
    .allele_freq (allele_freq),
    .last_marker (last_marker),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .dosage      (dosage),
    .invalid_pair(invalid_pair),
    .last_result (last_result)
  );

  dosage_scoreboard sb = new();

  // stall rates in percent, changed only on a rising edge
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: ready redrawn on every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor: results are checked before the new input is noted; a marker
  // taken on this edge cannot have its result out on the same edge anyway.
  // The watchdog counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_dosage(dosage, invalid_pair, last_result);
      if (in_valid && in_ready)
        sb.note_marker(sib1_bit_a, sib1_bit_b, sib2_bit_a, sib2_bit_b,
                       allele_freq, last_marker);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_sibling_maternal_dosage_unit NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  // Present one marker and hold it until the transfer. Starts on a falling
  // edge; a sender gap lowers valid first. Returns on the accepting edge and
  // leaves valid high, so the next call can drive straight on.
  task automatic send_marker(input geno_t g1, input geno_t g2,
                             input logic [FREQ_W-1:0] freq, input logic is_last);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid    <= 1'b1;
    sib1_bit_a  <= ~g1[0];
    sib1_bit_b  <= ~g1[1];
    sib2_bit_a  <= ~g2[0];
    sib2_bit_b  <= ~g2[1];
    allele_freq <= freq;
    last_marker <= is_last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait for every predicted result to come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // mostly valid genotypes, invalid code now and then
  function automatic geno_t pick_geno();
    case ($urandom_range(2))
      0: pick_geno = ($urandom_range(99) < 15) ? GT_BAD : GT_HOM_ALT;
      1: pick_geno = ($urandom_range(99) < 15) ? GT_BAD : GT_HET;
      default: pick_geno = ($urandom_range(99) < 15) ? GT_BAD : GT_AA;
    endcase
  endfunction

  // uniform frequencies, with extra weight near both ends and mid-scale
  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(9))
      0: pick_freq = FREQ_W'($urandom_range(15));
      1: pick_freq = ~FREQ_W'($urandom_range(15));
      2: pick_freq = 16'h8000 ^ FREQ_W'($urandom_range(3));
      default: pick_freq = FREQ_W'($urandom);
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    geno_t codes[4];
    codes = '{GT_HOM_ALT, GT_HET, GT_BAD, GT_AA};

    rst         = 1'b1;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    sib1_bit_a  = 1'b0;
    sib1_bit_b  = 1'b0;
    sib2_bit_a  = 1'b0;
    sib2_bit_b  = 1'b0;
    allele_freq = '0;
    last_marker = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every genotype pair pattern, including the invalid code on
    // either side, at zero or full-scale frequency in turn.
    for (int i = 0; i < 16; i++)
      send_marker(codes[i / 4], codes[i % 4], (i % 2) ? 16'hFFFF : 16'h0000,
                  (i % 5) == 0);
    // heterozygous pair at low and mid-scale, the near-2.0 hom-alt pair, and two mixed pairs
    send_marker(GT_HET, GT_HET, 16'h0001, 1'b0);
    send_marker(GT_HET, GT_HET, 16'h8000, 1'b0);
    send_marker(GT_HET, GT_HET, 16'h7FFF, 1'b1);
    send_marker(GT_HOM_ALT, GT_HOM_ALT, 16'hFFFE, 1'b0);
    send_marker(GT_AA, GT_HET, 16'h0001, 1'b0);
    send_marker(GT_HOM_ALT, GT_HET, 16'h8000, 1'b1);
    drain_results();

    // Random phases: slow receiver, then slow sender, then full rate.
    // The sender drains the pipe between phases.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 86 : 0;
      rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 37 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_marker(pick_geno(), pick_geno(), pick_freq(),
                    (n == PHASE_ITEMS - 1) || ($urandom_range(99) < 5));
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_sibling_maternal_dosage_unit OK");
    end else begin
      $display("tb_sibling_maternal_dosage_unit NOT OK");
    end
    $finish;
  end

endmodule

// File: sibling_maternal_dosage_unit.f
+incdir+src
src/smdos_pkg.sv
src/smdos_prep.sv
src/smdos_cell.sv
src/sibling_maternal_dosage_unit.sv
src/smdos_checker.sv
tb/tb_sibling_maternal_dosage_unit.sv
